// ===== design/deque_with_search_macros.svh =====
// Assertion macros for the deque_with_search block.
// Each macro samples on clock and is disabled while reset is high.
`ifndef DEQUE_WITH_SEARCH_MACROS_SVH
`define DEQUE_WITH_SEARCH_MACROS_SVH

// Same-cycle implication.
`define DWS_ASSERT_IMP(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication.
`define DWS_ASSERT_NXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ===== design/dws_pkg.sv =====
// Shared types, constants and helpers for the deque_with_search block.
// No dependencies.
package dws_pkg;

   localparam int DEPTH      = 32;
   localparam int DATA_WIDTH = 32;
   localparam int ADDR_W     = $clog2(DEPTH);
   localparam int CNT_W      = $clog2(DEPTH + 1);
   localparam int OPC_W      = 3;
   localparam int KIND_W     = 3;
   localparam int ELEM_W     = 32;
   localparam int POS_W      = 6;

   typedef enum logic [OPC_W-1:0] {
      OP_PUSH_FRONT = 3'd0,
      OP_PUSH_BACK  = 3'd1,
      OP_LIST_FWD   = 3'd2,
      OP_LIST_BACK  = 3'd3,
      OP_FIND_FWD   = 3'd4,
      OP_FIND_BACK  = 3'd5
   } opcode_type;

   typedef enum logic [KIND_W-1:0] {
      KIND_ELEMENT = 3'd0,
      KIND_MATCH   = 3'd1,
      KIND_DONE    = 3'd2,
      KIND_ACCEPT  = 3'd3,
      KIND_FULL    = 3'd4
   } kind_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_WALK,
      ST_DONE
   } state_type;

   typedef struct packed {
      logic               valid;
      kind_type           kind;
      logic [ELEM_W-1:0]  element;
      logic [POS_W-1:0]   position;
      logic               last;
   } rsp_type;

   // (a + b) mod DEPTH for a, b below DEPTH
   function automatic logic [ADDR_W-1:0] wrap_add(input logic [ADDR_W-1:0] a,
                                                  input logic [ADDR_W-1:0] b);
      logic [ADDR_W:0] sum;
      sum = {1'b0, a} + {1'b0, b};
      if (sum >= (ADDR_W+1)'(DEPTH)) begin
         sum = sum - (ADDR_W+1)'(DEPTH);
      end
      return sum[ADDR_W-1:0];
   endfunction

endpackage

// ===== design/deque_with_search.sv =====
// Bounded double-ended queue of signed values with list and find runs.
// Command channel: an item (req_opcode, req_value) is taken at a rising edge
// with start high and busy low. Opcodes: push front, push back, list front to
// back, list back to front, find from front, find from back.
// Result channel: every beat is shown for exactly one cycle with rsp_valid
// high; the receiver cannot stall it. rsp_last marks the final beat of an item.
// Pushes: one beat (accepted, or refused when full) in the cycle after the
// push is taken; busy stays low, so a command may be taken every cycle.
// List and find: the stored entries are walked through the 32-entry store,
// one read a cycle; entry beats pass the RAM read register and the output
// register, and a done beat closes the run.
// The rate of list/find is set by the single read port of the store.
// Reset empties the queue (front index and count cleared) and drops any run
// in flight; store contents are not cleared and are only read once pushed.
// Depends on dws_pkg, dws_ram, dws_ctrl and deque_with_search_macros.svh.
`include "deque_with_search_macros.svh"

module deque_with_search (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              start,
   output logic                              busy,
   input  logic [dws_pkg::OPC_W-1:0]         req_opcode,
   input  logic signed [31:0]                req_value,
   output logic                              rsp_valid,
   output logic [dws_pkg::KIND_W-1:0]        rsp_kind,
   output logic signed [31:0]                rsp_element,
   output logic [dws_pkg::POS_W-1:0]         rsp_position,
   output logic                              rsp_last
);
   import dws_pkg::*;

   logic                    wr_en;
   logic [ADDR_W-1:0]       wr_addr;
   logic [DATA_WIDTH-1:0]   wr_data;
   logic                    rd_en;
   logic [ADDR_W-1:0]       rd_addr;
   logic [DATA_WIDTH-1:0]   rd_data;
   rsp_type                 rsp_in;
   rsp_type                 rsp_ff;

   dws_ctrl u_ctrl (
      .clock   (clock),
      .reset   (reset),
      .start   (start),
      .opcode  (req_opcode),
      .value   (req_value[DATA_WIDTH-1:0]),
      .busy    (busy),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_data (rd_data),
      .rsp     (rsp_in)
   );

   dws_ram #(
      .WIDTH   (DATA_WIDTH),
      .ENTRIES (DEPTH)
   ) u_ram (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   // output register: one beat per cycle, valid cleared by reset
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_ff <= '0;
      end else begin
         rsp_ff <= rsp_in;
      end
   end

   assign rsp_valid    = rsp_ff.valid;
   assign rsp_kind     = rsp_ff.kind;
   assign rsp_element  = rsp_ff.element;
   assign rsp_position = rsp_ff.position;
   assign rsp_last     = rsp_ff.last;

   `DWS_ASSERT_NXT(a_push_ack,
      start && !busy && (req_opcode == OP_PUSH_FRONT || req_opcode == OP_PUSH_BACK),
      rsp_valid && rsp_last && (rsp_kind == KIND_ACCEPT || rsp_kind == KIND_FULL),
      "push without acknowledge beat")
   `DWS_ASSERT_IMP(a_run_done, $fell(busy) && !$past(reset),
      rsp_valid && rsp_last && rsp_kind == KIND_DONE,
      "walk ended without done beat")
   `DWS_ASSERT_IMP(a_mid_beat, rsp_valid && !rsp_last,
      rsp_kind == KIND_ELEMENT || rsp_kind == KIND_MATCH,
      "non-final beat of wrong kind")

endmodule

// ===== design/dws_ram.sv =====
// Generic single-port-write, single-port-read synchronous RAM.
// Read data is registered. No dependencies.
module dws_ram #(
   parameter int WIDTH   = 32,
   parameter int ENTRIES = 32
) (
   input  logic                       clock,
   input  logic                       wr_en,
   input  logic [$clog2(ENTRIES)-1:0] wr_addr,
   input  logic [WIDTH-1:0]           wr_data,
   input  logic                       rd_en,
   input  logic [$clog2(ENTRIES)-1:0] rd_addr,
   output logic [WIDTH-1:0]           rd_data
);

   logic [WIDTH-1:0] mem [ENTRIES];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== design/dws_ctrl.sv =====
// Deque sequencer: ring pointers, push handling and the list/find walk.
// Depends on dws_pkg and drives the dws_ram ports.
module dws_ctrl (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              start,
   input  logic [dws_pkg::OPC_W-1:0]         opcode,
   input  logic [dws_pkg::DATA_WIDTH-1:0]    value,
   output logic                              busy,
   output logic                              wr_en,
   output logic [dws_pkg::ADDR_W-1:0]        wr_addr,
   output logic [dws_pkg::DATA_WIDTH-1:0]    wr_data,
   output logic                              rd_en,
   output logic [dws_pkg::ADDR_W-1:0]        rd_addr,
   input  logic [dws_pkg::DATA_WIDTH-1:0]    rd_data,
   output dws_pkg::rsp_type                  rsp
);
   import dws_pkg::*;

   state_type              state_ff, state_in;
   logic [ADDR_W-1:0]      front_ff, front_in;
   logic [CNT_W-1:0]       occ_ff, occ_in;
   logic [CNT_W-1:0]       cnt_ff, cnt_in;
   logic [CNT_W-1:0]       iss_ff, iss_in;
   logic [DATA_WIDTH-1:0]  val_ff, val_in;
   logic                   back_ff, back_in;
   logic                   find_ff, find_in;
   logic                   rdv_ff, rdv_in;
   logic [CNT_W-1:0]       rdpos_ff, rdpos_in;
   logic [ADDR_W-1:0]      new_front;
   logic [CNT_W-1:0]       walk_off;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         front_ff <= '0;
         occ_ff   <= '0;
         rdv_ff   <= 1'b0;
      end else begin
         state_ff <= state_in;
         front_ff <= front_in;
         occ_ff   <= occ_in;
         rdv_ff   <= rdv_in;
      end
   end

   always_ff @(posedge clock) begin
      cnt_ff   <= cnt_in;
      iss_ff   <= iss_in;
      val_ff   <= val_in;
      back_ff  <= back_in;
      find_ff  <= find_in;
      rdpos_ff <= rdpos_in;
   end

   assign new_front = (front_ff == '0) ? ADDR_W'(DEPTH - 1) : front_ff - 1'b1;
   // offset from the front slot of the entry being issued
   assign walk_off  = back_ff ? (cnt_ff - 1'b1 - iss_ff) : iss_ff;

   always_comb begin
      state_in = state_ff;
      front_in = front_ff;
      occ_in   = occ_ff;
      cnt_in   = cnt_ff;
      iss_in   = iss_ff;
      val_in   = val_ff;
      back_in  = back_ff;
      find_in  = find_ff;
      rdv_in   = 1'b0;
      rdpos_in = rdpos_ff;
      wr_en    = 1'b0;
      wr_addr  = front_ff;
      wr_data  = value;
      rd_en    = 1'b0;
      rd_addr  = wrap_add(front_ff, walk_off[ADDR_W-1:0]);
      rsp      = '0;

      case (state_ff)
         ST_IDLE: begin
            if (start) begin
               case (opcode_type'(opcode))
                  OP_PUSH_FRONT, OP_PUSH_BACK: begin
                     rsp.valid = 1'b1;
                     rsp.last  = 1'b1;
                     if (occ_ff == CNT_W'(DEPTH)) begin
                        rsp.kind = KIND_FULL;
                     end else begin
                        rsp.kind = KIND_ACCEPT;
                        wr_en    = 1'b1;
                        occ_in   = occ_ff + 1'b1;
                        if (opcode_type'(opcode) == OP_PUSH_FRONT) begin
                           front_in = new_front;
                           wr_addr  = new_front;
                        end else begin
                           wr_addr = wrap_add(front_ff, occ_ff[ADDR_W-1:0]);
                        end
                     end
                  end
                  OP_LIST_FWD, OP_LIST_BACK, OP_FIND_FWD, OP_FIND_BACK: begin
                     state_in = ST_WALK;
                     cnt_in   = occ_ff;
                     iss_in   = '0;
                     val_in   = value;
                     back_in  = (opcode_type'(opcode) == OP_LIST_BACK) ||
                                (opcode_type'(opcode) == OP_FIND_BACK);
                     find_in  = (opcode_type'(opcode) == OP_FIND_FWD) ||
                                (opcode_type'(opcode) == OP_FIND_BACK);
                  end
                  default: begin
                  end
               endcase
            end
         end
         ST_WALK: begin
            if (iss_ff != cnt_ff) begin
               rd_en    = 1'b1;
               iss_in   = iss_ff + 1'b1;
               rdv_in   = 1'b1;
               rdpos_in = iss_ff + 1'b1;
            end else begin
               state_in = ST_DONE;
            end
            // read data of the previous issue arrives now
            if (rdv_ff && (!find_ff || (rd_data == val_ff))) begin
               rsp.valid    = 1'b1;
               rsp.kind     = find_ff ? KIND_MATCH : KIND_ELEMENT;
               rsp.element  = ELEM_W'(rd_data);
               rsp.position = POS_W'(rdpos_ff);
            end
         end
         ST_DONE: begin
            rsp.valid = 1'b1;
            rsp.kind  = KIND_DONE;
            rsp.last  = 1'b1;
            state_in  = ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   assign busy = (state_ff != ST_IDLE);

endmodule
